// ===== sv/calendar_time_set_editor_macros.svh =====
// Assertion macros for the calendar time-set editor.
// No dependencies; included by calendar_time_set_editor.sv, which checks its own logic.
`ifndef CALENDAR_TIME_SET_EDITOR_MACROS_SVH
`define CALENDAR_TIME_SET_EDITOR_MACROS_SVH
`ifndef SYNTHESIS
`define CTSE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define CTSE_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CTSE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CTSE_ASSERT(lbl, clk, rst, prop, msg)
`define CTSE_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define CTSE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== sv/ctse_pkg.sv =====
// Types, constants and the month-length function of the calendar time-set editor.
// No dependencies.
package ctse_pkg;

   typedef enum logic [1:0] {
      CMD_SELECT = 2'd0,
      CMD_INC    = 2'd1,
      CMD_DEC    = 2'd2,
      CMD_LOAD   = 2'd3
   } cmd_type;

   localparam logic [2:0] FIELD_YEAR   = 3'd0;
   localparam logic [2:0] FIELD_MONTH  = 3'd1;
   localparam logic [2:0] FIELD_DAY    = 3'd2;
   localparam logic [2:0] FIELD_HOUR   = 3'd3;
   localparam logic [2:0] FIELD_MINUTE = 3'd4;
   localparam logic [2:0] FIELD_SECOND = 3'd5;
   localparam logic [2:0] FIELD_LAST   = FIELD_SECOND;

   localparam logic [6:0] YEAR_MAX  = 7'd99;
   localparam logic [3:0] MONTH_MAX = 4'd12;
   localparam logic [4:0] HOUR_MAX  = 5'd23;
   localparam logic [5:0] MIN_MAX   = 6'd59;

   typedef struct packed {
      cmd_type    cmd;
      logic [6:0] load_year;
      logic [3:0] load_month;
      logic [4:0] load_day;
      logic [4:0] load_hour;
      logic [5:0] load_minute;
      logic [5:0] load_second;
   } req_type;

   typedef struct packed {
      logic [6:0] year_out;
      logic [3:0] month_out;
      logic [4:0] day_out;
      logic [4:0] hour_out;
      logic [5:0] minute_out;
      logic [5:0] second_out;
      logic [2:0] field_pointer;
   } rsp_type;

   typedef struct packed {
      logic [6:0] year;
      logic [3:0] month;
      logic [4:0] day;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [2:0] pointer;
   } state_type;

   localparam state_type RESET_STATE = '{
      year: 7'd0, month: 4'd1, day: 5'd1, hour: 5'd0,
      minute: 6'd0, second: 6'd0, pointer: FIELD_YEAR
   };

   // zero for a month that has no meaning
   function automatic logic [4:0] month_length(logic [3:0] month, logic [6:0] year);
      logic [4:0] len;
      case (month) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:    len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

// ===== sv/ctse_stream_if.sv =====
// Valid/ready stream interface carrying one payload word.
// Payload type is a parameter; used with the types of ctse_pkg.
interface ctse_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/ctse_next.sv =====
// Next-state logic of the calendar time-set editor: one command applied to the fields.
// Depends on ctse_pkg.
module ctse_next (
   input  ctse_pkg::state_type cur,
   input  ctse_pkg::req_type   req,
   output ctse_pkg::state_type nxt
);

   logic [2:0] sel;
   logic       sel_y, sel_mo, sel_d, sel_h, sel_mi, sel_s;

   // increment path, one bit wider than the fields
   logic [7:0] y_inc;
   logic [4:0] mo_inc;
   logic [5:0] d_inc;
   logic [5:0] h_inc;
   logic [6:0] mi_inc, s_inc;
   logic [6:0] y_inc_n;
   logic [3:0] mo_inc_n;
   logic [4:0] lim_inc;
   logic [4:0] d_inc_n;

   // decrement path
   logic [6:0] y_dec;
   logic [3:0] mo_dec;
   logic [4:0] d_dec;
   logic       d_under;
   logic [4:0] lim_dec;
   logic [4:0] d_dec_n;

   assign sel    = cur.pointer;
   assign sel_y  = (sel == ctse_pkg::FIELD_YEAR);
   assign sel_mo = (sel == ctse_pkg::FIELD_MONTH);
   assign sel_d  = (sel == ctse_pkg::FIELD_DAY);
   assign sel_h  = (sel == ctse_pkg::FIELD_HOUR);
   assign sel_mi = (sel == ctse_pkg::FIELD_MINUTE);
   assign sel_s  = (sel == ctse_pkg::FIELD_SECOND);

   always_comb begin
      y_inc  = {1'b0, cur.year}   + 8'(sel_y);
      mo_inc = {1'b0, cur.month}  + 5'(sel_mo);
      d_inc  = {1'b0, cur.day}    + 6'(sel_d);
      h_inc  = {1'b0, cur.hour}   + 6'(sel_h);
      mi_inc = {1'b0, cur.minute} + 7'(sel_mi);
      s_inc  = {1'b0, cur.second} + 7'(sel_s);

      y_inc_n  = (y_inc > {1'b0, ctse_pkg::YEAR_MAX}) ? 7'd0 : y_inc[6:0];
      mo_inc_n = (mo_inc > {1'b0, ctse_pkg::MONTH_MAX}) ? 4'd1 : mo_inc[3:0];
      lim_inc  = ctse_pkg::month_length(mo_inc_n, y_inc_n);
      if ((lim_inc != 5'd0) && (d_inc > {1'b0, lim_inc})) begin
         d_inc_n = 5'd1;
      end else begin
         d_inc_n = d_inc[4:0];
      end

      y_dec   = sel_y ? ((cur.year == 7'd0) ? ctse_pkg::YEAR_MAX : cur.year - 7'd1)
                      : cur.year;
      mo_dec  = cur.month - 4'(sel_mo);
      if ((cur.month == 4'd0) || (sel_mo && (cur.month == 4'd1))) begin
         mo_dec = ctse_pkg::MONTH_MAX;
      end
      d_under = sel_d && (cur.day == 5'd0);
      d_dec   = cur.day - 5'(sel_d);
      lim_dec = ctse_pkg::month_length(mo_dec, y_dec);
      if (lim_dec == 5'd0) begin
         d_dec_n = d_dec;
      end else if (d_under || (d_dec == 5'd0)) begin
         d_dec_n = lim_dec;
      end else if (d_dec > lim_dec) begin
         d_dec_n = 5'd1;
      end else begin
         d_dec_n = d_dec;
      end

      nxt = cur;
      case (req.cmd)
         ctse_pkg::CMD_SELECT: begin
            nxt.pointer = (cur.pointer == ctse_pkg::FIELD_LAST) ? ctse_pkg::FIELD_YEAR
                                                                : cur.pointer + 3'd1;
         end
         ctse_pkg::CMD_INC: begin
            nxt.year   = y_inc_n;
            nxt.month  = mo_inc_n;
            nxt.day    = d_inc_n;
            nxt.hour   = (h_inc > {1'b0, ctse_pkg::HOUR_MAX}) ? 5'd0 : h_inc[4:0];
            nxt.minute = (mi_inc > {1'b0, ctse_pkg::MIN_MAX}) ? 6'd0 : mi_inc[5:0];
            nxt.second = (s_inc > {1'b0, ctse_pkg::MIN_MAX}) ? 6'd0 : s_inc[5:0];
         end
         ctse_pkg::CMD_DEC: begin
            nxt.year   = y_dec;
            nxt.month  = mo_dec;
            nxt.day    = d_dec_n;
            nxt.hour   = sel_h ? ((cur.hour == 5'd0) ? ctse_pkg::HOUR_MAX
                                                     : cur.hour - 5'd1) : cur.hour;
            nxt.minute = sel_mi ? ((cur.minute == 6'd0) ? ctse_pkg::MIN_MAX
                                                        : cur.minute - 6'd1) : cur.minute;
            nxt.second = sel_s ? ((cur.second == 6'd0) ? ctse_pkg::MIN_MAX
                                                       : cur.second - 6'd1) : cur.second;
         end
         ctse_pkg::CMD_LOAD: begin
            nxt.year   = req.load_year;
            nxt.month  = req.load_month;
            nxt.day    = req.load_day;
            nxt.hour   = req.load_hour;
            nxt.minute = req.load_minute;
            nxt.second = req.load_second;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

// ===== sv/calendar_time_set_editor.sv =====
// Calendar time-set editor: six time fields, a field pointer, one result word per command.
// Usage:
//   req_ch carries one command word (cmd and the six load values). Commands:
//   select next field (pointer wraps after second), increment the selected
//   field with every field above its limit then wrapped, decrement it with
//   wrap and the day fitted to the month, or load all six fields unchecked.
//   rsp_ch returns the six fields and the pointer after each command.
//   The result word is registered: it is valid in the cycle after the command is taken.
//   Throughput: one command per cycle unless rsp_ch stalls; the field registers
//   and the output register both update at the accepting edge, so the next
//   command sees the new fields at once.
//   Stall: while a result word waits on rsp_ch, req_ch.ready stays high only
//   if rsp_ch.ready is high in the same cycle; the waiting word holds.
//   Reset (synchronous): fields go to year 0, month 1, day 1, 00:00:00,
//   pointer on year; no result word is pending.
// Depends on ctse_pkg, ctse_stream_if, ctse_next and the assertion macros.
`include "calendar_time_set_editor_macros.svh"
module calendar_time_set_editor (
   input logic clock,
   input logic reset,
   ctse_stream_if.sink   req_ch,
   ctse_stream_if.source rsp_ch
);

   ctse_pkg::state_type state_ff, state_in;
   ctse_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic                rsp_valid_ff;
   logic                accept;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   ctse_next u_next (
      .cur (state_ff),
      .req (req_ch.payload),
      .nxt (state_in)
   );

   assign rsp_data_in = '{
      year_out:      state_in.year,
      month_out:     state_in.month,
      day_out:       state_in.day,
      hour_out:      state_in.hour,
      minute_out:    state_in.minute,
      second_out:    state_in.second,
      field_pointer: state_in.pointer
   };

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ctse_pkg::RESET_STATE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   `CTSE_ASSERT(a_ptr_range, clock, reset, state_ff.pointer <= ctse_pkg::FIELD_LAST, "pointer out of range")
   `CTSE_ASSERT_IMPL(a_rsp_mirrors_state, clock, reset, rsp_valid_ff, (rsp_data_ff.year_out == state_ff.year) && (rsp_data_ff.day_out == state_ff.day) && (rsp_data_ff.field_pointer == state_ff.pointer), "result word differs from fields")
   `CTSE_ASSERT_NEXT(a_accept_gives_rsp, clock, reset, accept, rsp_valid_ff, "taken command left no result word")
   `CTSE_ASSERT_NEXT(a_select_keeps_time, clock, reset, accept && (req_ch.payload.cmd == ctse_pkg::CMD_SELECT), $stable(state_ff.year) && $stable(state_ff.month) && $stable(state_ff.day) && $stable(state_ff.hour) && $stable(state_ff.minute) && $stable(state_ff.second), "select changed a time field")
   `CTSE_ASSERT_NEXT(a_inc_in_range, clock, reset, accept && (req_ch.payload.cmd == ctse_pkg::CMD_INC), (state_ff.year <= ctse_pkg::YEAR_MAX) && (state_ff.month <= ctse_pkg::MONTH_MAX) && (state_ff.hour <= ctse_pkg::HOUR_MAX) && (state_ff.minute <= ctse_pkg::MIN_MAX) && (state_ff.second <= ctse_pkg::MIN_MAX), "increment left a field out of range")

endmodule

// ===== tb/tb_calendar_time_set_editor.sv =====
// Testbench for calendar_time_set_editor: directed edits, then random edit streams.
// Depends on ctse_pkg, ctse_stream_if and the RTL; predicts every result word itself.
`timescale 1ns / 1ps
module tb_calendar_time_set_editor;
   import ctse_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic clock;
   logic reset;

   ctse_stream_if #(.payload_type(req_type)) req_ch ();
   ctse_stream_if #(.payload_type(rsp_type)) rsp_ch ();

   calendar_time_set_editor uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   state_type editor_state;
   rsp_type   pending_fields[$];
   int        error_count = 0;
   int        sent_count;
   int        checked_count = 0;
   int        cycle_count = 0;
   int        send_idle_pct;
   int        recv_idle_pct;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                  pending_fields.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic int days_in(int month, int year);
      case (month)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         2:                     return (year % 4 == 0) ? 29 : 28;
         default:               return 0;
      endcase
   endfunction

   function automatic state_type predict_edit(state_type s, req_type w);
      int        f[6];
      int        lim;
      state_type n;
      n = s;
      f[FIELD_YEAR]   = s.year;
      f[FIELD_MONTH]  = s.month;
      f[FIELD_DAY]    = s.day;
      f[FIELD_HOUR]   = s.hour;
      f[FIELD_MINUTE] = s.minute;
      f[FIELD_SECOND] = s.second;
      case (w.cmd)
         CMD_SELECT: begin
            n.pointer = 3'((int'(s.pointer) + 1) % 6);
         end
         CMD_INC: begin
            if (s.pointer <= FIELD_LAST) f[s.pointer] += 1;
            if (f[FIELD_YEAR] > 99) f[FIELD_YEAR] = 0;
            if (f[FIELD_MONTH] > 12) f[FIELD_MONTH] = 1;
            lim = days_in(f[FIELD_MONTH], f[FIELD_YEAR]);
            if (lim != 0 && f[FIELD_DAY] > lim) f[FIELD_DAY] = 1;
            if (f[FIELD_HOUR] > 23) f[FIELD_HOUR] = 0;
            if (f[FIELD_MINUTE] > 59) f[FIELD_MINUTE] = 0;
            if (f[FIELD_SECOND] > 59) f[FIELD_SECOND] = 0;
         end
         CMD_DEC: begin
            if (s.pointer <= FIELD_LAST) f[s.pointer] -= 1;
            if (f[FIELD_YEAR] < 0) f[FIELD_YEAR] = 99;
            if (f[FIELD_MONTH] < 1) f[FIELD_MONTH] = 12;
            lim = days_in(f[FIELD_MONTH], f[FIELD_YEAR]);
            if (lim != 0) begin
               if (f[FIELD_DAY] < 1) f[FIELD_DAY] = lim;
               if (f[FIELD_DAY] > lim) f[FIELD_DAY] = 1;
            end
            if (f[FIELD_HOUR] < 0) f[FIELD_HOUR] = 23;
            if (f[FIELD_MINUTE] < 0) f[FIELD_MINUTE] = 59;
            if (f[FIELD_SECOND] < 0) f[FIELD_SECOND] = 59;
         end
         default: begin
            f[FIELD_YEAR]   = w.load_year;
            f[FIELD_MONTH]  = w.load_month;
            f[FIELD_DAY]    = w.load_day;
            f[FIELD_HOUR]   = w.load_hour;
            f[FIELD_MINUTE] = w.load_minute;
            f[FIELD_SECOND] = w.load_second;
         end
      endcase
      n.year   = 7'(f[FIELD_YEAR]);
      n.month  = 4'(f[FIELD_MONTH]);
      n.day    = 5'(f[FIELD_DAY]);
      n.hour   = 5'(f[FIELD_HOUR]);
      n.minute = 6'(f[FIELD_MINUTE]);
      n.second = 6'(f[FIELD_SECOND]);
      return n;
   endfunction

   function automatic req_type cmd_word(cmd_type c);
      req_type w;
      w.cmd         = c;
      w.load_year   = 7'($urandom);
      w.load_month  = 4'($urandom);
      w.load_day    = 5'($urandom);
      w.load_hour   = 5'($urandom);
      w.load_minute = 6'($urandom);
      w.load_second = 6'($urandom);
      return w;
   endfunction

   function automatic req_type load_word(int y, int mo, int d, int h, int mi, int s);
      req_type w;
      w.cmd         = CMD_LOAD;
      w.load_year   = 7'(y);
      w.load_month  = 4'(mo);
      w.load_day    = 5'(d);
      w.load_hour   = 5'(h);
      w.load_minute = 6'(mi);
      w.load_second = 6'(s);
      return w;
   endfunction

   function automatic req_type random_edit_word();
      req_type w;
      int      r;
      int      mo;
      int      y;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         y  = $urandom_range(0, 99);
         mo = $urandom_range(1, 12);
         w  = load_word(y, mo, $urandom_range(1, days_in(mo, y)), $urandom_range(0, 23),
                        $urandom_range(0, 59), $urandom_range(0, 59));
      end else if (r < 12) begin
         w = cmd_word(CMD_LOAD);
      end else if (r < 40) begin
         w = cmd_word(CMD_SELECT);
      end else if (r < 70) begin
         w = cmd_word(CMD_INC);
      end else begin
         w = cmd_word(CMD_DEC);
      end
      return w;
   endfunction

   // entered and left at a falling edge
   task automatic send_word(req_type w);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= w;
      do @(posedge clock); while (!req_ch.ready);
      editor_state = predict_edit(editor_state, w);
      pending_fields.push_back(rsp_type'(editor_state));
      sent_count++;
      @(negedge clock);
   endtask

   task automatic hold_until_drained();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending_fields.size() != 0);
   endtask

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      rsp_type exp;
      rsp_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.payload;
         if (pending_fields.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected result word %p", got);
         end else begin
            exp = pending_fields.pop_front();
            checked_count++;
            if (got.year_out !== exp.year_out || got.month_out !== exp.month_out ||
                got.day_out !== exp.day_out || got.hour_out !== exp.hour_out ||
                got.minute_out !== exp.minute_out || got.second_out !== exp.second_out ||
                got.field_pointer !== exp.field_pointer) begin
               error_count++;
               if (error_count <= 10)
                  $display("word %0d: exp %0d-%0d-%0d %0d:%0d:%0d ptr %0d, ",
                           checked_count, exp.year_out, exp.month_out, exp.day_out,
                           exp.hour_out, exp.minute_out, exp.second_out, exp.field_pointer,
                           "got %0d-%0d-%0d %0d:%0d:%0d ptr %0d",
                           got.year_out, got.month_out, got.day_out,
                           got.hour_out, got.minute_out, got.second_out, got.field_pointer);
            end
         end
      end
   end

   // pointer starts on year; each field wraps both ways, pointer wraps after second
   task automatic test_field_wraps();
      send_word(load_word(99, 12, 31, 23, 59, 59));
      for (int k = 0; k < 6; k++) begin
         send_word(cmd_word(CMD_INC));
         send_word(cmd_word(CMD_DEC));
         send_word(cmd_word(CMD_SELECT));
      end
   endtask

   // leap February, day wrapped to 1 when the year leaves the leap
   task automatic test_leap_february();
      send_word(load_word(4, 2, 29, 12, 30, 30));
      send_word(cmd_word(CMD_INC));
      send_word(cmd_word(CMD_DEC));
   endtask

   // loads are unchecked; an out-of-range month leaves the day alone
   task automatic test_unchecked_loads();
      send_word(load_word(127, 15, 31, 31, 63, 63));
      send_word(cmd_word(CMD_INC));
      send_word(load_word(0, 0, 0, 0, 0, 0));
      send_word(cmd_word(CMD_DEC));
      send_word(load_word(0, 13, 0, 0, 0, 0));
      send_word(cmd_word(CMD_DEC));
      send_word(load_word(0, 0, 0, 0, 0, 0));
      send_word(cmd_word(CMD_INC));
   endtask

   task automatic test_random_edits(int count, int send_pct, int recv_pct, bit drain_mid);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int k = 0; k < count; k++) begin
         if (drain_mid && k == count / 2) hold_until_drained();
         send_word(random_edit_word());
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      editor_state   = RESET_STATE;
      sent_count     = 0;
      send_idle_pct  = 28;
      recv_idle_pct  = 64;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_field_wraps();
      test_leap_february();
      test_unchecked_loads();
      test_random_edits(420, 28, 64, 1'b1);
      test_random_edits(420, 64, 28, 1'b0);
      test_random_edits(420, 0, 0, 1'b0);

      hold_until_drained();
      repeat (5) @(posedge clock);

      $display("%0d commands sent, %0d result words checked: field wraps, leap February,",
               sent_count, checked_count);
      $display("unchecked loads and random edit streams under three stall mixes");
      if (error_count == 0 && pending_fields.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/ctse_pkg.sv
sv/ctse_stream_if.sv
sv/ctse_next.sv
sv/calendar_time_set_editor.sv
tb/tb_calendar_time_set_editor.sv
